// ----- hdl/blr_pkg.sv -----
// shared types and constants for the line rasterizer
// no dependencies; used by every module of the block

package blr_pkg;

    localparam int COORD_W       = 12;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int ERR_W         = 15;
    localparam int CHAN_W        = 8;
    localparam int COLOUR_W      = 24;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = QPTR_W + 1;

    localparam int S_TDATA_W     = 4 * COORD_W + COLOUR_W;
    localparam int M_TDATA_W     = 2 * COORD_W + COLOUR_W;

    // request kinds on the slave tuser bit
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // one classified command as it travels from front to back
    typedef struct packed {
        logic                       req_type;
        logic                       steep;
        logic signed [COORD_W-1:0]  major_start;
        logic signed [COORD_W-1:0]  minor_start;
        logic signed [COORD_W-1:0]  major_end;
        logic                       minor_neg;
        logic signed [ERR_W-1:0]    error_init;
        logic signed [ERR_W-1:0]    inc_straight;
        logic signed [ERR_W-1:0]    inc_diagonal;
        logic [COLOUR_W-1:0]        colour;
    } t_cmd;

endpackage

// ----- hdl/blr_front.sv -----
// front end: accepts request beats, registers endpoint deltas, then does line setup
// depends on blr_pkg

module blr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic [blr_pkg::S_TDATA_W-1:0]       i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output blr_pkg::t_cmd                       o_cmd
);

    localparam int CW  = blr_pkg::COORD_W;
    localparam int DW  = blr_pkg::DIFF_W;
    localparam int EW  = blr_pkg::ERR_W;
    localparam int CHW = blr_pkg::CHAN_W;

    logic                          r_vld;
    logic                          r_req;
    logic signed [CW-1:0]          r_xs, r_ys, r_xe, r_ye;
    logic signed [DW-1:0]          r_dx, r_dy;
    logic [blr_pkg::COLOUR_W-1:0]  r_colour;

    logic signed [CW-1:0] w_xs, w_ys, w_xe, w_ye;
    logic                 w_accept;

    logic [DW-1:0]        adx, ady, dmaj, dmin;
    logic signed [DW-1:0] maj_d, min_d;
    logic                 steep, swap;
    logic signed [CW-1:0] ma_s, ma_e, mi_s, mi_e;

    assign w_xs = i_data[CW-1:0];
    assign w_ys = i_data[2*CW-1:CW];
    assign w_xe = i_data[3*CW-1:2*CW];
    assign w_ye = i_data[4*CW-1:3*CW];

    assign o_ready  = !r_vld || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req_type;
            r_xs     <= w_xs;
            r_ys     <= w_ys;
            r_xe     <= w_xe;
            r_ye     <= w_ye;
            r_dx     <= {w_xe[CW-1], w_xe} - {w_xs[CW-1], w_xs};
            r_dy     <= {w_ye[CW-1], w_ye} - {w_ys[CW-1], w_ys};
            // red arrives lowest in tdata but sits on top of the colour word
            r_colour <= {i_data[4*CW +: CHW],
                         i_data[4*CW+CHW +: CHW],
                         i_data[4*CW+2*CHW +: CHW]};
        end
    end

    // setup: steep on ties, order along major axis, midpoint increments
    always_comb begin
        adx   = r_dx[DW-1] ? -r_dx : r_dx;
        ady   = r_dy[DW-1] ? -r_dy : r_dy;
        steep = !(ady < adx);
        maj_d = steep ? r_dy : r_dx;
        min_d = steep ? r_dx : r_dy;
        dmaj  = steep ? ady : adx;
        dmin  = steep ? adx : ady;
        swap  = maj_d[DW-1];
        ma_s  = steep ? r_ys : r_xs;
        ma_e  = steep ? r_ye : r_xe;
        mi_s  = steep ? r_xs : r_ys;
        mi_e  = steep ? r_xe : r_ye;

        o_cmd.req_type     = r_req;
        o_cmd.steep        = steep;
        o_cmd.major_start  = swap ? ma_e : ma_s;
        o_cmd.minor_start  = swap ? mi_e : mi_s;
        o_cmd.major_end    = swap ? ma_s : ma_e;
        o_cmd.minor_neg    = (min_d != '0) && (min_d[DW-1] ^ swap);
        o_cmd.error_init   = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
        o_cmd.inc_straight = {1'b0, dmin, 1'b0};
        o_cmd.inc_diagonal = EW'({1'b0, dmin, 1'b0}) - EW'({1'b0, dmaj, 1'b0});
        o_cmd.colour       = r_colour;
    end

endmodule

// ----- hdl/blr_queue.sv -----
// short command queue between front and back
// depends on blr_pkg

module blr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  blr_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output blr_pkg::t_cmd   o_cmd
);

    blr_pkg::t_cmd                 r_mem [blr_pkg::QUEUE_DEPTH];
    logic [blr_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [blr_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == blr_pkg::QCNT_W'(blr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/blr_back.sv -----
// back end: holds the active line, steps the error term, drives the pixel register
// depends on blr_pkg

module blr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  blr_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [blr_pkg::M_TDATA_W-1:0]     o_data,
    output logic                              o_in_bounds,
    output logic                              o_last
);

    localparam int CW = blr_pkg::COORD_W;
    localparam int EW = blr_pkg::ERR_W;

    logic                          r_active, r_steep, r_neg;
    logic signed [CW-1:0]          r_major, r_minor, r_major_end;
    logic signed [EW-1:0]          r_err, r_inc_s, r_inc_d;
    logic [blr_pkg::COLOUR_W-1:0]  r_colour;

    logic                          r_out_valid;
    logic [blr_pkg::M_TDATA_W-1:0] r_out_data;
    logic                          r_out_inb, r_out_last;

    logic                 is_load, emit;
    logic signed [CW-1:0] px, py;
    logic                 last, inb;
    logic signed [CW-1:0] n_major, n_minor;
    logic signed [EW-1:0] n_err;

    assign is_load = (i_cmd.req_type == blr_pkg::REQ_LOAD);
    assign o_pop   = !i_empty && (is_load || !r_active || !r_out_valid || i_ready);
    assign emit    = o_pop && !is_load && r_active;

    always_comb begin
        px   = r_steep ? r_minor : r_major;
        py   = r_steep ? r_major : r_minor;
        last = (r_major >= r_major_end);
        inb  = !px[CW-1] && !py[CW-1]
            && ({1'b0, px} < (CW+1)'(blr_pkg::SCREEN_WIDTH))
            && ({1'b0, py} < (CW+1)'(blr_pkg::SCREEN_HEIGHT));
        n_major = r_major + 1'b1;
        if (r_err > 0) begin
            n_minor = r_neg ? r_minor - 1'b1 : r_minor + 1'b1;
            n_err   = r_err + r_inc_d;
        end else begin
            n_minor = r_minor;
            n_err   = r_err + r_inc_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && is_load) begin
                r_active <= 1'b1;
            end else if (emit && last) begin
                r_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_load) begin
            r_steep     <= i_cmd.steep;
            r_major     <= i_cmd.major_start;
            r_minor     <= i_cmd.minor_start;
            r_major_end <= i_cmd.major_end;
            r_neg       <= i_cmd.minor_neg;
            r_err       <= i_cmd.error_init;
            r_inc_s     <= i_cmd.inc_straight;
            r_inc_d     <= i_cmd.inc_diagonal;
            r_colour    <= i_cmd.colour;
        end else if (emit && !last) begin
            r_major <= n_major;
            r_minor <= n_minor;
            r_err   <= n_err;
        end
        if (emit) begin
            r_out_data <= {r_colour, py, px};
            r_out_inb  <= inb;
            r_out_last <= last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign o_in_bounds = r_out_inb;
    assign o_last      = r_out_last;

endmodule

// ----- hdl/bresenham_line_rasterizer_top.sv -----
// bresenham line rasterizer: one pixel per tick beat while a line is active, up to one beat per cycle
// a tick taken into the front register is written into the queue, then popped into the pixel output register
// a load needs no gap: a tick may follow it in the very next cycle
// throughput: one request beat per cycle, limited only by master-side back-pressure
// reset: synchronous active-low i_rst_n empties the pipeline and queue, no line is active
// depends on blr_pkg, blr_front, blr_queue, blr_back

module bresenham_line_rasterizer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: x_start[11:0] y_start[23:12] x_end[35:24] y_end[47:36]
    //        red[55:48] green[63:56] blue[71:64]
    input  logic [blr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: req_type[0] (0 load, 1 tick)
    input  logic [0:0]                         s_axis_tuser,
    // pixel channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_x[11:0] pixel_y[23:12] pixel_word[47:24]
    output logic [blr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // tuser: in_bounds[0]
    output logic [0:0]                         m_axis_tuser,
    // tlast: last_pixel
    output logic                               m_axis_tlast
);

    // front side: setup result waiting for a queue slot
    logic          front_valid;
    blr_pkg::t_cmd front_cmd;

    // queue status and head command
    logic          q_full, q_empty, q_pop;
    blr_pkg::t_cmd q_cmd;

    // front stage registers deltas and classifies loads (steep/shallow, order, error setup)
    blr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser[0]),
        .i_data     (s_axis_tdata),
        .o_valid    (front_valid),
        .i_ready    (!q_full),
        .o_cmd      (front_cmd)
    );

    // small queue lets the front keep taking beats while the pixel side stalls
    blr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // back end: loads replace the active line at once, ticks step it one pixel
    blr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_in_bounds (m_axis_tuser[0]),
        .o_last      (m_axis_tlast)
    );

endmodule

// ----- hdl/blr_checker.sv -----
// port-level checks for the line rasterizer, bound to the top level
// depends on blr_pkg and bresenham_line_rasterizer_top

module blr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [blr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    localparam int CW = blr_pkg::COORD_W;

    // a stalled pixel beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("pixel beat changed while stalled");

    // in_bounds only on pixels inside the screen
    a_inb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
        !m_axis_tdata[CW-1] && !m_axis_tdata[2*CW-1]
        && ({1'b0, m_axis_tdata[CW-1:0]} < (CW+1)'(blr_pkg::SCREEN_WIDTH))
        && ({1'b0, m_axis_tdata[2*CW-1:CW]} < (CW+1)'(blr_pkg::SCREEN_HEIGHT)))
        else $error("in_bounds set on off-screen pixel");

    // pixels with a negative coordinate must not carry in_bounds
    a_oob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[CW-1] || m_axis_tdata[2*CW-1]) |->
        !m_axis_tuser[0])
        else $error("negative coordinate flagged in bounds");

    // reset leaves no pixel pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("pixel valid right after reset");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (.*);
